// ===== hw/rtl/mfm_pkg.sv =====
// Package with shared constants, codes and types of the MFM sector decoder.
package mfm_pkg;

    localparam int SECTORS_PER_TRACK = 11;
    localparam int WORDS_PER_SECTOR  = 128;
    localparam int TRACK_COUNT       = 160;
    localparam int HDR_LONGS         = 14;

    localparam logic [31:0] DATA_MASK = 32'h55555555;
    localparam logic [31:0] PREAMBLE  = 32'h2AAAAAAA;
    localparam logic [31:0] SYNC_LONG = 32'h44894489;

    localparam logic [7:0] REG_CURRENT_TRACK = 8'd0;
    localparam logic [7:0] REG_FORMAT_BYTE   = 8'd1;

    typedef enum logic [1:0] {
        ST_DATA   = 2'd0,
        ST_GOOD   = 2'd1,
        ST_BAD    = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] offset;
    } sync_hit_t;

    function automatic logic [31:0] join_halves(input logic [31:0] odd, input logic [31:0] even);
        join_halves = ((odd & DATA_MASK) << 1) | (even & DATA_MASK);
    endfunction

endpackage

// ===== hw/rtl/mfm_if.sv =====
// Handshake interfaces for the raw word, result and configuration channels.
interface mfm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] mfm_word;
    logic        restart;
    modport source (output valid, mfm_word, restart, input ready);
    modport sink   (input valid, mfm_word, restart, output ready);
endinterface

interface mfm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [3:0]  sector;
    logic [6:0]  word_index;
    logic [3:0]  gap_order;
    logic [1:0]  status;
    logic        last;
    modport source (output valid, data_word, sector, word_index, gap_order, status, last,
                    input ready);
    modport sink   (input valid, data_word, sector, word_index, gap_order, status, last,
                    output ready);
endinterface

interface mfm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mfm_sync_search.sv =====
// Sync search over all sixteen bit offsets of the word history.
module mfm_sync_search (
    input  logic [63:0]        history,
    input  logic [15:0]        word,
    output mfm_pkg::sync_hit_t result
);

    logic [79:0] cat;
    logic [63:0] win;

    assign cat = {history, word};

    // Scan from the top offset down so the lowest matching offset wins.
    always_comb
    begin
        result = '0;
        win    = '0;
        for (int s = 15; s >= 0; s--)
        begin
            win = cat[(16 - s) +: 64];
            if (win[62:32] == mfm_pkg::PREAMBLE[30:0] && win[31:0] == mfm_pkg::SYNC_LONG)
            begin
                result.hit    = 1'b1;
                result.offset = 4'(s);
            end
        end
    end

endmodule

// ===== hw/rtl/mfm_sector_decoder.sv =====
// Top level of the MFM sector decoder: alignment, header checks, data decode.
//
//  channel  dir  payload
//  words    in   mfm_word[15:0], restart
//  results  out  data_word, sector, word_index, gap_order, status, last
//  cfg      in   index[7:0], data[7:0] (always ready)
//
// One raw word is taken every cycle while words.ready is high; each word
// is decoded in the cycle it is accepted and its result is then registered.
// The output register decouples the sides: words stay ready while the held
// result is being taken in the same cycle or when no result is held.
// The odd-half store is a 128-entry memory, read ahead of its use.
// Reset clears all control state at once; no clearing pass is needed.
module mfm_sector_decoder (
    input  logic          clk,
    input  logic          rst_n,
    mfm_in_if.sink        words,
    mfm_out_if.source     results,
    mfm_cfg_if.sink       cfg
);

    localparam int W = mfm_pkg::WORDS_PER_SECTOR;

    logic [7:0]  current_track_reg, format_byte_reg;
    logic [15:0] previous_word_reg;
    logic [63:0] history_reg;
    logic        locked_reg;
    logic [3:0]  offset_reg;
    logic [9:0]  wp_reg;
    logic [15:0] partial_reg;
    logic [31:0] id_reg, hxor_reg, hchk_reg, dchk_reg, dxor_reg;
    logic [31:0] odd_store [W];
    logic [31:0] rd_reg;

    logic        res_valid_reg;
    logic [31:0] res_data_reg;
    logic [3:0]  res_sector_reg, res_gap_reg;
    logic [6:0]  res_index_reg;
    logic [1:0]  res_status_reg;
    logic        res_last_reg;

    logic        accept;
    logic [63:0] hist_e;
    logic        locked_e;
    logic [9:0]  wp_e;
    mfm_pkg::sync_hit_t hit;
    logic [31:0] cat32;
    logic [15:0] aligned;
    logic [31:0] raw;
    logic [8:0]  idx;
    logic [8:0]  di;
    logic [31:0] rhc_full;
    logic [31:0] dxor_fin;
    logic        hdr_ok;
    logic        fin;

    logic        locked_next;
    logic [3:0]  offset_next;
    logic [9:0]  wp_next;
    logic [15:0] partial_next;
    logic [31:0] id_next, hxor_next, hchk_next, dchk_next, dxor_next;
    logic        emit;
    logic [31:0] e_data;
    logic [3:0]  e_sector, e_gap;
    logic [6:0]  e_index;
    mfm_pkg::status_t e_status;
    logic        e_last;
    logic        mem_we, mem_re;

    assign words.ready   = !res_valid_reg || results.ready;
    assign accept        = words.valid && words.ready;
    assign cfg.ready     = 1'b1;

    assign hist_e   = words.restart ? 64'd0 : history_reg;
    assign locked_e = words.restart ? 1'b0 : locked_reg;
    assign wp_e     = words.restart ? 10'd0 : wp_reg;

    mfm_sync_search u_search (
        .history (hist_e),
        .word    (words.mfm_word),
        .result  (hit)
    );

    assign cat32    = {previous_word_reg, words.mfm_word} >> (5'd16 - {1'b0, offset_reg});
    assign aligned  = cat32[15:0];
    assign raw      = {partial_reg, aligned};
    assign idx      = wp_e[9:1];
    assign di       = idx - 9'(mfm_pkg::HDR_LONGS + W);
    assign rhc_full = mfm_pkg::join_halves(hchk_reg, raw);
    assign dxor_fin = dxor_reg ^ raw;
    assign fin      = (di == 9'(W - 1));

    assign hdr_ok = (id_reg[31:24] == format_byte_reg)
                 && ({1'b0, id_reg[23:16]} < 9'(mfm_pkg::TRACK_COUNT))
                 && (id_reg[15:8] < 8'(mfm_pkg::SECTORS_PER_TRACK))
                 && (id_reg[7:0] >= 8'd1)
                 && (id_reg[7:0] <= 8'(mfm_pkg::SECTORS_PER_TRACK))
                 && ((hxor_reg & mfm_pkg::DATA_MASK) == rhc_full)
                 && (id_reg[23:16] == current_track_reg);

    always_comb
    begin
        locked_next  = locked_e;
        offset_next  = offset_reg;
        wp_next      = wp_e;
        partial_next = partial_reg;
        id_next      = id_reg;
        hxor_next    = hxor_reg;
        hchk_next    = hchk_reg;
        dchk_next    = dchk_reg;
        dxor_next    = dxor_reg;
        emit         = 1'b0;
        e_data       = '0;
        e_sector     = '0;
        e_index      = '0;
        e_gap        = '0;
        e_status     = mfm_pkg::ST_DATA;
        e_last       = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        if (!locked_e)
        begin
            if (hit.hit)
            begin
                locked_next = 1'b1;
                offset_next = hit.offset;
                wp_next     = '0;
            end
        end
        else if (!wp_e[0])
        begin
            partial_next = aligned;
            wp_next      = wp_e + 10'd1;
            mem_re       = 1'b1;
        end
        else
        begin
            wp_next = wp_e + 10'd1;
            if (idx == 9'd0)
            begin
                id_next   = raw;
                hxor_next = raw;
            end
            else if (idx == 9'd1)
            begin
                hxor_next = hxor_reg ^ raw;
                id_next   = mfm_pkg::join_halves(id_reg, raw);
            end
            else if (idx < 9'd10)
            begin
                hxor_next = hxor_reg ^ raw;
            end
            else if (idx == 9'd10)
            begin
                hchk_next = raw;
            end
            else if (idx == 9'd11)
            begin
                hchk_next = rhc_full;
                if (!hdr_ok)
                begin
                    emit        = 1'b1;
                    e_status    = mfm_pkg::ST_REJECT;
                    e_last      = 1'b1;
                    locked_next = 1'b0;
                end
            end
            else if (idx == 9'd12)
            begin
                dchk_next = raw;
            end
            else if (idx == 9'd13)
            begin
                dchk_next = mfm_pkg::join_halves(dchk_reg, raw);
                dxor_next = '0;
            end
            else if (idx < 9'(mfm_pkg::HDR_LONGS + W))
            begin
                mem_we    = 1'b1;
                dxor_next = dxor_fin;
            end
            else if (idx < 9'(mfm_pkg::HDR_LONGS + 2 * W))
            begin
                dxor_next = dxor_fin;
                emit      = 1'b1;
                e_data    = mfm_pkg::join_halves(rd_reg, raw);
                e_sector  = id_reg[11:8];
                e_index   = di[6:0];
                e_gap     = id_reg[3:0];
                if (fin)
                begin
                    e_last      = 1'b1;
                    locked_next = 1'b0;
                    e_status    = ((dxor_fin & mfm_pkg::DATA_MASK) == dchk_reg)
                                  ? mfm_pkg::ST_GOOD : mfm_pkg::ST_BAD;
                end
            end
            else
            begin
                locked_next = 1'b0;
            end
        end
    end

    // Odd halves are written in the odd phase; the matching entry is read on
    // the first word of each even-phase long, ahead of its use.
    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
        begin
            odd_store[7'(idx - 9'(mfm_pkg::HDR_LONGS))] <= raw;
        end
        if (accept && mem_re)
        begin
            rd_reg <= odd_store[di[6:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_track_reg <= '0;
            format_byte_reg   <= 8'hFF;
            previous_word_reg <= '0;
            history_reg       <= '0;
            locked_reg        <= 1'b0;
            offset_reg        <= '0;
            wp_reg            <= '0;
            partial_reg       <= '0;
            id_reg            <= '0;
            hxor_reg          <= '0;
            hchk_reg          <= '0;
            dchk_reg          <= '0;
            dxor_reg          <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.index == mfm_pkg::REG_CURRENT_TRACK)
            begin
                current_track_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == mfm_pkg::REG_FORMAT_BYTE)
            begin
                format_byte_reg <= cfg.data;
            end
            if (accept)
            begin
                previous_word_reg <= words.mfm_word;
                history_reg       <= {hist_e[47:0], words.mfm_word};
                locked_reg        <= locked_next;
                offset_reg        <= offset_next;
                wp_reg            <= wp_next;
                partial_reg       <= partial_next;
                id_reg            <= id_next;
                hxor_reg          <= hxor_next;
                hchk_reg          <= hchk_next;
                dchk_reg          <= dchk_next;
                dxor_reg          <= dxor_next;
                res_valid_reg     <= emit;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_data_reg   <= e_data;
            res_sector_reg <= e_sector;
            res_index_reg  <= e_index;
            res_gap_reg    <= e_gap;
            res_status_reg <= e_status;
            res_last_reg   <= e_last;
        end
    end

    assign results.valid      = res_valid_reg;
    assign results.data_word  = res_data_reg;
    assign results.sector     = res_sector_reg;
    assign results.word_index = res_index_reg;
    assign results.gap_order  = res_gap_reg;
    assign results.status     = res_status_reg;
    assign results.last       = res_last_reg;

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == mfm_pkg::ST_REJECT |-> results.last)
        else $error("header rejection without last");

    a_last_not_data: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.last |-> results.status != mfm_pkg::ST_DATA)
        else $error("last beat carries plain data status");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == mfm_pkg::ST_REJECT
        |-> results.data_word == 32'd0 && results.gap_order == 4'd0)
        else $error("rejection beat carries nonzero payload");

    a_unlock_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && e_last |=> !locked_reg)
        else $error("still aligned after end of sector");

endmodule
